/* hw/rtl/byte_level_token_text_decoder_unit_assert.svh */
// assertion macros shared by the decoder modules
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_UNIT_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_UNIT_ASSERT_SVH

// condition and consequence checked at the same edge
`define BTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked at the next edge after the condition
`define BTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/btd_pkg.sv */
// types, constants and the inverse byte map of the token text decoder
`timescale 1ns / 1ps

package btd_pkg;

  // input request: one byte of a stored token string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // output request: one decoded raw byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_t;

  // work handed from front to back: up to four bytes to emit
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            str_end;
  } job_t;

  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD2_MASK    = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE    = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK    = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE    = 8'hE0;
  localparam logic [7:0]  CONT_MASK     = 8'h3F;
  localparam logic [7:0]  LEAD2_BITS    = 8'h1F;
  localparam logic [7:0]  LEAD3_BITS    = 8'h0F;
  localparam logic [7:0]  LEAD4_BITS    = 8'h07;
  localparam logic [20:0] MAP_LOW       = 21'd256;
  localparam logic [20:0] MAP_HIGH      = 21'd323;
  localparam logic [6:0]  MAP_SPLIT1    = 7'd33;
  localparam logic [6:0]  MAP_SPLIT2    = 7'd67;
  localparam logic [7:0]  MAP_OFFSET    = 8'd94;
  localparam logic [7:0]  MAP_SOFT_HYPH = 8'd173;

  // inverse of the printable remap; n is the code point minus 256
  function automatic logic [7:0] inverse_map(input logic [6:0] n);
    logic [7:0] r;
    if (n < MAP_SPLIT1) begin
      r = {1'b0, n};
    end else if (n < MAP_SPLIT2) begin
      r = {1'b0, n} + MAP_OFFSET;
    end else begin
      r = MAP_SOFT_HYPH;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/btd_front.sv */
// front end: utf-8 sequence assembly and code point classification
`timescale 1ns / 1ps

module btd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          token_valid,
  output logic          token_ready,
  input  btd_pkg::in_t  token,
  input  logic          q_full,
  output logic          push,
  output btd_pkg::job_t push_job
);

  logic [20:0] partial;
  logic [1:0]  expected;
  logic [1:0]  held_count;
  logic [7:0]  held [3];

  logic        accept;
  logic        is_lead;
  logic [20:0] partial_next;
  logic [1:0]  expected_next;
  logic [1:0]  held_count_next;
  logic        held_we;
  logic [1:0]  held_idx;
  logic [3:0][7:0] raw;
  logic        finish;
  logic [7:0]  b;

  assign b           = token.in_byte;
  assign token_ready = !q_full;
  assign accept      = token_valid && token_ready;
  assign is_lead     = (expected == 2'd0);

  always_comb begin
    partial_next    = '0;
    expected_next   = 2'd0;
    held_count_next = 2'd1;
    held_we         = 1'b1;
    held_idx        = 2'd0;
    if (is_lead) begin
      priority if (b < btd_pkg::ASCII_LIMIT) begin
        partial_next  = {13'd0, b};
        expected_next = 2'd0;
      end else if ((b & btd_pkg::LEAD2_MASK) == btd_pkg::LEAD2_CODE) begin
        partial_next  = {13'd0, b & btd_pkg::LEAD2_BITS};
        expected_next = 2'd1;
      end else if ((b & btd_pkg::LEAD3_MASK) == btd_pkg::LEAD3_CODE) begin
        partial_next  = {13'd0, b & btd_pkg::LEAD3_BITS};
        expected_next = 2'd2;
      end else begin
        partial_next  = {13'd0, b & btd_pkg::LEAD4_BITS};
        expected_next = 2'd3;
      end
    end else begin
      partial_next    = {partial[14:0], b[5:0]};
      expected_next   = expected - 2'd1;
      held_count_next = held_count + 2'd1;
      held_we         = (held_count != 2'd3);
      held_idx        = held_count;
    end
  end

  // raw bytes of the open sequence with this request's byte merged in
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw[i] = (held_we && (held_idx == 2'(i))) ? b : held[i];
    end
    raw[3] = b;
  end

  assign finish = (expected_next == 2'd0) || token.in_last;
  assign push   = accept && finish;

  always_comb begin
    push_job          = '0;
    push_job.str_end  = token.in_last;
    if (partial_next < btd_pkg::MAP_LOW) begin
      push_job.bytes[0] = partial_next[7:0];
      push_job.last_idx = 2'd0;
    end else if (partial_next <= btd_pkg::MAP_HIGH) begin
      push_job.bytes[0] = btd_pkg::inverse_map(7'(partial_next - btd_pkg::MAP_LOW));
      push_job.last_idx = 2'd0;
    end else begin
      // a count of zero means all four bytes arrived
      push_job.bytes    = raw;
      push_job.last_idx = held_count_next - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      expected   <= 2'd0;
      held_count <= 2'd0;
    end else if (accept) begin
      if (finish) begin
        partial    <= '0;
        expected   <= 2'd0;
        held_count <= 2'd0;
      end else begin
        partial    <= partial_next;
        expected   <= expected_next;
        held_count <= held_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[held_idx] <= b;
    end
  end

endmodule

/* hw/rtl/btd_queue.sv */
// small fifo of decoded jobs between front and back
`timescale 1ns / 1ps
`include "byte_level_token_text_decoder_unit_assert.svh"

module btd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  btd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output btd_pkg::job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  btd_pkg::job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `BTD_ASSERT_NOW(a_no_push_full, clk, rst, full, !push, "push into full queue")
  `BTD_ASSERT_NOW(a_no_pop_empty, clk, rst, !head_valid, !pop, "pop from empty queue")
  `BTD_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overrun")

endmodule

/* hw/rtl/btd_back.sv */
// back end: per unstalled cycle, moves a job byte into the output register
`timescale 1ns / 1ps
`include "byte_level_token_text_decoder_unit_assert.svh"

module btd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  btd_pkg::job_t head_job,
  output logic          pop,
  output logic          text_valid,
  input  logic          text_ready,
  output btd_pkg::out_t text
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = head_valid && (!text_valid || text_ready);
  assign at_end = (idx == head_job.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 2'd0;
      text_valid <= 1'b0;
    end else begin
      if (load) begin
        idx        <= at_end ? 2'd0 : idx + 2'd1;
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text.out_byte   <= head_job.bytes[idx];
      text.byte_valid <= 1'b1;
      text.run_last   <= at_end;
      text.string_end <= head_job.str_end;
    end
  end

  `BTD_ASSERT_NOW(a_idx_idle, clk, rst, !head_valid, idx == 2'd0, "byte index left open")
  `BTD_ASSERT_NOW(a_idx_range, clk, rst, head_valid, idx <= head_job.last_idx, "index past job")
  `BTD_ASSERT_NEXT(a_pop_run_last, clk, rst, pop, text_valid && text.run_last, "job end lost")
  `BTD_ASSERT_NOW(a_byte_flag, clk, rst, text_valid, text.byte_valid, "result without byte")

endmodule

/* hw/rtl/byte_level_token_text_decoder_unit.sv */
// a taken request's result is held in the job queue, then in the output register
// throughput: one input request per cycle; one output byte per cycle unless stalled
// a raw pass-through emits two to four output bytes; the job queue absorbs the burst
// input ready drops only while the job queue is full
// reset: synchronous, clears sequence state, queue pointers and output valid
`timescale 1ns / 1ps

module byte_level_token_text_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  // byte requests of the token string
  input  logic          token_valid,
  output logic          token_ready,
  input  btd_pkg::in_t  token,
  // decoded raw byte requests
  output logic          text_valid,
  input  logic          text_ready,
  output btd_pkg::out_t text
);

  // front to queue
  logic          push;
  btd_pkg::job_t push_job;
  logic          q_full;

  // queue to back
  logic          pop;
  logic          head_valid;
  btd_pkg::job_t head_job;

  // front: gathers the utf-8 sequence, maps the finished code point,
  // and hands the bytes to emit as one job
  btd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // job queue decouples byte intake from multi-byte output bursts
  btd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: one byte per unstalled cycle into the output register, run_last on the
  // final byte of each job, string_end on every byte of the closing job
  btd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

endmodule

/* tb/byte_level_token_text_decoder_unit_test.sv */
// self-checking bench for the byte-level token text decoder: table-driven and random strings
`timescale 1ns / 1ps

module byte_level_token_text_decoder_unit_test;

  // stop guard, far above the slowest legal run of a few hundred requests
  localparam int CYCLE_LIMIT = 200000;
  // total byte requests, directed table included
  localparam int BYTE_TARGET = 220;
  localparam int PLAN_ROWS   = 25;

  // one directed row: the byte, its last flag, and a typed-in result where
  // the answer is obvious (single decoded byte, no predictor needed)
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [7:0] typed_byte;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic token_valid = 1'b0;
  logic token_ready;
  btd_pkg::in_t  token = '0;
  logic text_valid;
  logic text_ready = 1'b0;
  btd_pkg::out_t text;

  // decoder state mirrored by the bench
  logic [20:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;
  logic [7:0]  raw_hold [0:2];
  logic [1:0]  raw_count = '0;

  btd_pkg::out_t decoded [0:3];
  btd_pkg::out_t text_due [$];
  btd_pkg::out_t want;

  int  sent = 0;
  int  checked = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  // directed table: ascii extremes, mapped range ends and middle split,
  // pass-through for two, three and four byte sequences, a 0xff lead,
  // a stray continuation byte as lead, and two sequences cut short
  step_t plan [0:PLAN_ROWS-1] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00},   // lowest ascii, ends the string
    '{8'h7F, 1'b0, 1'b1, 8'h7F},   // highest ascii, string stays open
    '{8'hC4, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b1, 1'b1, 8'h00},   // code point 256 maps back to byte 0
    '{8'hC5, 1'b0, 1'b0, 8'h00},
    '{8'h83, 1'b0, 1'b1, 8'hAD},   // code point 323 maps to the soft hyphen
    '{8'hC4, 1'b0, 1'b0, 8'h00},
    '{8'hA1, 1'b0, 1'b1, 8'h7F},   // code point 289, first of the upper block
    '{8'hC3, 1'b0, 1'b0, 8'h00},
    '{8'hBF, 1'b0, 1'b1, 8'hFF},   // code point 255 passes as that byte
    '{8'hC5, 1'b0, 1'b0, 8'h00},
    '{8'h84, 1'b1, 1'b0, 8'h00},   // code point 324, raw two bytes
    '{8'hE4, 1'b0, 1'b0, 8'h00},
    '{8'hB8, 1'b0, 1'b0, 8'h00},
    '{8'hAD, 1'b0, 1'b0, 8'h00},   // three byte raw pass-through
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00},   // 0xff lead, four raw bytes
    '{8'h80, 1'b1, 1'b1, 8'h00},   // stray continuation as lead, cut at once
    '{8'hE2, 1'b0, 1'b0, 8'h00},
    '{8'h82, 1'b1, 1'b0, 8'h00},   // three byte lead cut after two
    '{8'hF4, 1'b0, 1'b0, 8'h00},
    '{8'h8F, 1'b0, 1'b0, 8'h00},
    '{8'hBF, 1'b1, 1'b0, 8'h00}    // four byte lead cut after three, raw
  };

  byte_level_token_text_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text        (text)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decoded bytes still due", cycles,
               text_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure: about one stall in ten, none in the calm stretch
  always @(posedge clk) begin
    text_ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  // decoded byte checker, oldest expectation first
  always @(posedge clk) begin
    if (!rst && text_valid && text_ready) begin
      if (text_due.size() == 0) begin
        errors++;
        $display("%0t: decoded byte with nothing due: byte %h valid %b run_last %b end %b",
                 $time, text.out_byte, text.byte_valid, text.run_last, text.string_end);
      end else begin
        want = text_due.pop_front();
        checked++;
        if (text.out_byte !== want.out_byte || text.byte_valid !== want.byte_valid ||
            text.run_last !== want.run_last || text.string_end !== want.string_end) begin
          errors++;
          $display("%0t: mismatch, expected byte %h valid %b run_last %b end %b,",
                   $time, want.out_byte, want.byte_valid, want.run_last, want.string_end);
          $display("    got byte %h valid %b run_last %b end %b",
                   text.out_byte, text.byte_valid, text.run_last, text.string_end);
        end
      end
    end
  end

  // append one expected decoded byte to the end of the due list
  task automatic add_due(input btd_pkg::out_t x);
    text_due = {text_due, x};
  endtask

  // advance the mirrored decoder by one byte; fills decoded[0..n-1]
  task automatic decode_byte(input btd_pkg::in_t r, output int n);
    logic [7:0] b;
    logic [2:0] nraw;
    logic [6:0] off;
    int i;
    b = r.in_byte;
    n = 0;
    if (cont_left == 2'd0) begin
      // lead byte picks the sequence length
      if (b < btd_pkg::ASCII_LIMIT) begin
        cp_acc = {13'd0, b};
        cont_left = 2'd0;
      end else if ((b & btd_pkg::LEAD2_MASK) == btd_pkg::LEAD2_CODE) begin
        cp_acc = {13'd0, b & btd_pkg::LEAD2_BITS};
        cont_left = 2'd1;
      end else if ((b & btd_pkg::LEAD3_MASK) == btd_pkg::LEAD3_CODE) begin
        cp_acc = {13'd0, b & btd_pkg::LEAD3_BITS};
        cont_left = 2'd2;
      end else begin
        cp_acc = {13'd0, b & btd_pkg::LEAD4_BITS};
        cont_left = 2'd3;
      end
      raw_hold[0] = b;
      raw_count = 2'd1;
    end else begin
      // continuation: top bits ignored
      cp_acc = {cp_acc[14:0], b[5:0]};
      if (raw_count < 2'd3) raw_hold[raw_count] = b;
      raw_count = raw_count + 2'd1;
      cont_left = cont_left - 2'd1;
    end
    // count wraps to zero only on the fourth byte
    nraw = (raw_count == 2'd0) ? 3'd4 : {1'b0, raw_count};
    if (cont_left == 2'd0 || r.in_last) begin
      if (cp_acc < 21'd256) begin
        decoded[0].out_byte = cp_acc[7:0];
        n = 1;
      end else if (cp_acc <= 21'd323) begin
        off = 7'(cp_acc - 21'd256);
        if (off < 7'd33) decoded[0].out_byte = {1'b0, off};
        else if (off < 7'd67) decoded[0].out_byte = {1'b0, off} + 8'd94;
        else decoded[0].out_byte = 8'd173;
        n = 1;
      end else begin
        // raw pass-through of the bytes actually present
        for (i = 0; i < nraw; i++) decoded[i].out_byte = (i == 3) ? b : raw_hold[i];
        n = nraw;
      end
      for (i = 0; i < n; i++) begin
        decoded[i].byte_valid = 1'b1;
        decoded[i].run_last = (i == n - 1);
        decoded[i].string_end = r.in_last;
      end
      cp_acc = '0;
      cont_left = 2'd0;
      raw_count = 2'd0;
    end
  endtask

  // offer one byte request, wait for the handshake, then log what it should produce
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic [7:0] typed_byte);
    btd_pkg::in_t  r;
    btd_pkg::out_t lit;
    int   n;
    int   i;
    r.in_byte = b;
    r.in_last = last;
    if (!calm && $urandom_range(0, 99) < 10) begin
      token_valid <= 1'b0;
      @(posedge clk);
    end
    token_valid <= 1'b1;
    token <= r;
    do @(posedge clk); while (!token_ready);
    sent++;
    decode_byte(r, n);
    if (typed) begin
      lit.out_byte = typed_byte;
      lit.byte_valid = 1'b1;
      lit.run_last = 1'b1;
      lit.string_end = last;
      add_due(lit);
    end else begin
      for (i = 0; i < n; i++) add_due(decoded[i]);
    end
  endtask

  initial begin
    logic [20:0] cp;
    logic [7:0]  seq [0:3];
    int len;
    int ncp;
    int j;
    int k;
    bit drained;
    drained = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (j = 0; j < PLAN_ROWS; j++)
      send_byte(plan[j].b, plan[j].last, plan[j].typed, plan[j].typed_byte);

    // random strings: mostly well-formed code points, some noise
    while (sent < BYTE_TARGET) begin
      calm = (sent >= 100 && sent < 160);

      // once, hold off the sender until the decoder has delivered everything
      if (!drained && sent >= 180) begin
        drained = 1'b1;
        token_valid <= 1'b0;
        do @(posedge clk); while (text_due.size() != 0);
      end

      if ($urandom_range(0, 99) < 20) begin
        // noise: arbitrary bytes, arbitrary string ends
        len = $urandom_range(1, 5);
        for (j = 0; j < len; j++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, 8'h00);
      end else begin
        ncp = $urandom_range(1, 4);
        for (k = 0; k < ncp; k++) begin
          case ($urandom_range(0, 5))
            0: begin
              seq[0] = 8'($urandom_range(0, 127));
              len = 1;
            end
            1, 2, 3: begin
              // latin-1 range, remapped range, or plain two-byte pass-through
              cp = (k % 3 == 0) ? 21'($urandom_range(128, 255)) :
                   (k % 3 == 1) ? 21'($urandom_range(256, 323)) :
                                  21'($urandom_range(324, 2047));
              seq[0] = {3'b110, cp[10:6]};
              seq[1] = {2'b10, cp[5:0]};
              len = 2;
            end
            4: begin
              cp = 21'($urandom_range(2048, 65535));
              seq[0] = {4'b1110, cp[15:12]};
              seq[1] = {2'b10, cp[11:6]};
              seq[2] = {2'b10, cp[5:0]};
              len = 3;
            end
            default: begin
              cp = 21'($urandom_range(65536, 21'h1FFFFF));
              seq[0] = {5'b11110, cp[20:18]};
              seq[1] = {2'b10, cp[17:12]};
              seq[2] = {2'b10, cp[11:6]};
              seq[3] = {2'b10, cp[5:0]};
              len = 4;
            end
          endcase
          // now and then the string ends in the middle of its final sequence
          if (k == ncp - 1 && len > 1 && $urandom_range(0, 9) == 0)
            len = $urandom_range(1, len - 1);
          for (j = 0; j < len; j++)
            send_byte(seq[j], k == ncp - 1 && j == len - 1, 1'b0, 8'h00);
        end
      end
    end

    // drain, then leave room for any stray output
    calm = 1'b0;
    token_valid <= 1'b0;
    do @(posedge clk); while (text_due.size() != 0);
    repeat (20) @(posedge clk);

    $display("%0d byte requests sent, %0d decoded bytes checked, %0d mismatches",
             sent, checked, errors);
    $display("strings mixed ascii, remapped and pass-through code points");
    $display("with cut and malformed sequences under random stalls on both sides");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/btd_pkg.sv
hw/rtl/btd_front.sv
hw/rtl/btd_queue.sv
hw/rtl/btd_back.sv
hw/rtl/byte_level_token_text_decoder_unit.sv
tb/byte_level_token_text_decoder_unit_test.sv
